// ===== src/prru_pkg.sv =====
// Package for the permutation rank / unrank unit.
// Holds field widths, divider step size and the table control struct.
// No dependencies.
`default_nettype none

package prru_pkg;

	// Field widths fixed by the transaction format
	localparam int RANK_W = 45;
	localparam int ELEM_W = 4;
	localparam int CFG_W  = 5;

	// Layer count after reset
	localparam int LAYER_RESET = 16;

	// Quotient bits retired by the divider in one cycle
	localparam int DIV_STEP = 8;

	// Control strobes from the sequencer to the slot / location tables
	typedef struct packed {
		logic clear;
		logic slot_rd;
		logic loc_rd;
		logic slot_we;
		logic loc_we;
	} tbl_ctl_t;

endpackage

`default_nettype wire

// ===== src/prru_if.sv =====
// Valid / ready channel interfaces for the permutation rank / unrank unit.
// Depends on prru_pkg for the payload widths.
`default_nettype none

interface prru_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [prru_pkg::ELEM_W-1:0] element_in;
	logic [prru_pkg::RANK_W-1:0] unrank_index;

	modport source (output valid, action, element_in, unrank_index, input ready);
	modport sink   (input valid, action, element_in, unrank_index, output ready);
endinterface

interface prru_out_if;
	logic                        valid;
	logic                        ready;
	logic                        result_kind;
	logic [prru_pkg::RANK_W-1:0] rank_value;
	logic [prru_pkg::ELEM_W-1:0] element_out;
	logic                        last;
	logic                        error;

	modport source (output valid, result_kind, rank_value, element_out, last, error,
		input ready);
	modport sink   (input valid, result_kind, rank_value, element_out, last, error,
		output ready);
endinterface

`default_nettype wire

// ===== src/prru_divider.sv =====
// Iterative restoring divider of a rank-wide index by a small divisor.
// Retires prru_pkg::DIV_STEP quotient bits per cycle. Depends on prru_pkg.
`default_nettype none

module prru_divider #(
	parameter int DW = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [prru_pkg::RANK_W-1:0] dividend,
	input  logic [DW-1:0]               divisor,
	output logic [prru_pkg::RANK_W-1:0] quot,
	output logic [DW-1:0]               rem,
	output logic                        done
);

	localparam int RW    = prru_pkg::RANK_W;
	localparam int STEP  = prru_pkg::DIV_STEP;
	localparam int NSTEP = (RW + STEP - 1) / STEP;
	localparam int PW    = NSTEP * STEP;
	localparam int CTW   = $clog2(NSTEP);

	logic [PW-1:0]  sh_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  d_q;
	logic [CTW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DW:0]    r_c;
	logic [PW-1:0]  sh_c;

	// Shift in one dividend bit per step, subtract where the divisor fits
	always_comb begin
		r_c  = {1'b0, rem_q};
		sh_c = sh_q;
		for (int k = 0; k < STEP; k++) begin
			r_c  = {r_c[DW-1:0], sh_c[PW-1]};
			sh_c = {sh_c[PW-2:0], 1'b0};
			if (r_c >= {1'b0, d_q}) begin
				r_c     = r_c - {1'b0, d_q};
				sh_c[0] = 1'b1;
			end
		end
	end

	// Load on start, advance while busy, pulse done after the last group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q   <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sh_q   <= PW'(dividend);
				rem_q  <= '0;
				d_q    <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				sh_q  <= sh_c;
				rem_q <= r_c[DW-1:0];
				cnt_q <= cnt_q + CTW'(1);
				if (cnt_q == CTW'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = sh_q[RW-1:0];
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== src/prru_tables.sv =====
// Slot content and element location tables with registered reads.
// Entries never written since the last clear read as their own index.
// Depends on prru_pkg for the control struct.
`default_nettype none

module prru_tables #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prru_pkg::tbl_ctl_t  ctl,
	input  logic [AW-1:0]       slot_ra,
	input  logic [AW-1:0]       slot_rb,
	input  logic [AW-1:0]       slot_wa,
	input  logic [AW-1:0]       slot_wd,
	input  logic [AW-1:0]       loc_ra,
	input  logic [AW-1:0]       loc_wa,
	input  logic [AW-1:0]       loc_wd,
	output logic [AW-1:0]       slot_qa,
	output logic [AW-1:0]       slot_qb,
	output logic [AW-1:0]       loc_q
);

	logic [AW-1:0]    slot_mem [DEPTH];
	logic [AW-1:0]    loc_mem  [DEPTH];
	logic [DEPTH-1:0] slot_vld_q;
	logic [DEPTH-1:0] loc_vld_q;

	logic [AW-1:0] slot_da_q, slot_db_q, loc_d_q;
	logic [AW-1:0] slot_aa_q, slot_ab_q, loc_a_q;
	logic          slot_va_q, slot_vb_q, loc_v_q;

	// Track written entries; clear returns both tables to identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			loc_vld_q  <= '0;
		end else if (ctl.clear) begin
			slot_vld_q <= '0;
			loc_vld_q  <= '0;
		end else begin
			if (ctl.slot_we)
				slot_vld_q[slot_wa] <= 1'b1;
			if (ctl.loc_we)
				loc_vld_q[loc_wa] <= 1'b1;
		end
	end

	// Write ports
	always_ff @(posedge clk) begin
		if (ctl.slot_we)
			slot_mem[slot_wa] <= slot_wd;
		if (ctl.loc_we)
			loc_mem[loc_wa] <= loc_wd;
	end

	// Registered read ports; data, valid and address held until the next read
	always_ff @(posedge clk) begin
		if (ctl.slot_rd) begin
			slot_da_q <= slot_mem[slot_ra];
			slot_db_q <= slot_mem[slot_rb];
			slot_va_q <= slot_vld_q[slot_ra];
			slot_vb_q <= slot_vld_q[slot_rb];
			slot_aa_q <= slot_ra;
			slot_ab_q <= slot_rb;
		end
		if (ctl.loc_rd) begin
			loc_d_q <= loc_mem[loc_ra];
			loc_v_q <= loc_vld_q[loc_ra];
			loc_a_q <= loc_ra;
		end
	end

	assign slot_qa = slot_va_q ? slot_da_q : slot_aa_q;
	assign slot_qb = slot_vb_q ? slot_db_q : slot_ab_q;
	assign loc_q   = loc_v_q   ? loc_d_q   : loc_a_q;

endmodule

`default_nettype wire

// ===== src/permutation_rank_unrank_unit.sv =====
// Permutation rank / unrank unit: sequencer, rank datapath and output register.
// Depends on prru_pkg, prru_if, prru_divider and prru_tables.
`default_nettype none

// Ranks and unranks permutations of n elements (n = layer_count clamped to
// 2..MAX_LAYERS) with a swap-based mixed-radix scheme. The block takes one
// input transaction at a time. A rank transaction (action 0) carries the next
// element and steps through the read, check, accumulate and factor states;
// the n-th element also yields one rank result, which is loaded in the emit
// state and held in the output register until taken. An unrank transaction
// (action 1) yields n element results, the last one marked; each element
// waits on the divider, which retires eight quotient bits per cycle while
// busy. The rank datapath shares one 45x5-bit multiplier between the rank
// and factor updates. A layer_count write and an unrank transaction both
// drop any ranking in progress. Bad or repeated elements flag the rank result
// with error and a zero rank.
module permutation_rank_unrank_unit #(
	parameter int MAX_LAYERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [prru_pkg::CFG_W-1:0] cfg_wdata,
	prru_in_if.sink                    in_ch,
	prru_out_if.source                 out_ch
);

	localparam int RW    = prru_pkg::RANK_W;
	localparam int EW    = prru_pkg::ELEM_W;
	localparam int CFW   = prru_pkg::CFG_W;
	localparam int CNT_W = $clog2(MAX_LAYERS + 1);
	localparam int AW    = $clog2(MAX_LAYERS);
	localparam int N_RST = (prru_pkg::LAYER_RESET > MAX_LAYERS) ? MAX_LAYERS
		: prru_pkg::LAYER_RESET;

	typedef enum logic [2:0] {
		S_IDLE,
		S_R_READ,
		S_R_CHECK,
		S_R_ACC,
		S_R_FAC,
		S_R_EMIT,
		S_U_DIV,
		S_U_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  pos_q;
	logic [RW-1:0]     acc_q;
	logic [RW-1:0]     fac_q;
	logic              err_q;
	logic [EW-1:0]     e_q;
	logic              bad_q;
	logic [AW-1:0]     s_q;
	logic [AW-1:0]     v_q;
	logic [RW-1:0]     prod_q;
	logic [RW-1:0]     idx_q;
	logic [CNT_W-1:0]  i_q;
	logic [AW-1:0]     j_q;
	logic              div_start_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [RW-1:0]     out_rank_q;
	logic [EW-1:0]     out_elem_q;
	logic              out_last_q;
	logic              out_err_q;

	prru_pkg::tbl_ctl_t tbl_ctl;
	logic [AW-1:0]     slot_ra, slot_rb, slot_wa, slot_wd;
	logic [AW-1:0]     loc_ra, loc_wa, loc_wd;
	logic [AW-1:0]     slot_qa, slot_qb, loc_q;

	logic [RW-1:0]     div_quot;
	logic [CNT_W-1:0]  div_rem;
	logic              div_done;

	logic [CFW-1:0]    clamp_v;
	logic              e_big;
	logic              bad;
	logic [CNT_W-1:0]  diff;
	logic [CNT_W-1:0]  mul_b;
	logic [RW+CNT_W-1:0] prod_full;
	logic              out_free;
	logic [AW-1:0]     j_w;
	logic              last_el;
	logic [AW-1:0]     pos_a;
	logic [AW-1:0]     e_a;
	logic              div_kick;
	logic              out_load;

	// Clamp the written layer count to the supported range
	always_comb begin
		if (cfg_wdata < CFW'(2))
			clamp_v = CFW'(2);
		else if (cfg_wdata > CFW'(MAX_LAYERS))
			clamp_v = CFW'(MAX_LAYERS);
		else
			clamp_v = cfg_wdata;
	end

	// Rank checks and the shared multiplier
	assign pos_a     = pos_q[AW-1:0];
	assign e_a       = AW'(e_q);
	assign e_big     = CFW'(e_q) >= CFW'(n_q);
	assign bad       = e_big || (CNT_W'(loc_q) < pos_q);
	assign diff      = bad ? '0 : CNT_W'(loc_q) - pos_q;
	assign mul_b     = (state_q == S_R_CHECK) ? diff : n_q - pos_q;
	assign prod_full = fac_q * mul_b;

	// Unrank swap target and end of sequence
	assign j_w     = AW'(i_q + div_rem);
	assign last_el = (i_q == n_q - CNT_W'(1));

	assign out_free = !out_valid_q || out_ch.ready;

	// Start the divider on an unrank transaction or for the next element
	assign div_kick = (state_q == S_IDLE && !cfg_we && in_ch.valid && in_ch.action)
		|| (state_q == S_U_EMIT && out_free && !last_el);

	// Load the output register whenever a result is ready and the slot is free
	assign out_load = ((state_q == S_R_EMIT) || (state_q == S_U_EMIT)) && out_free;

	// Table strobes and addresses per sequencer state
	always_comb begin
		tbl_ctl = '0;
		slot_ra = pos_a;
		slot_rb = j_w;
		slot_wa = '0;
		slot_wd = '0;
		loc_ra  = e_a;
		loc_wa  = '0;
		loc_wd  = '0;
		unique case (state_q)
			S_IDLE: begin
				tbl_ctl.clear = cfg_we || (in_ch.valid && in_ch.action);
			end
			S_R_READ: begin
				tbl_ctl.slot_rd = 1'b1;
				tbl_ctl.loc_rd  = 1'b1;
			end
			S_R_CHECK: begin
				if (!bad) begin
					tbl_ctl.slot_we = 1'b1;
					slot_wa         = loc_q;
					slot_wd         = slot_qa;
					tbl_ctl.loc_we  = 1'b1;
					loc_wa          = e_a;
					loc_wd          = pos_a;
				end
			end
			S_R_ACC: begin
				if (!bad_q) begin
					tbl_ctl.slot_we = 1'b1;
					slot_wa         = pos_a;
					slot_wd         = e_a;
					tbl_ctl.loc_we  = 1'b1;
					loc_wa          = v_q;
					loc_wd          = s_q;
				end
			end
			S_R_FAC: begin
			end
			S_R_EMIT: begin
				tbl_ctl.clear = out_free;
			end
			S_U_DIV: begin
				tbl_ctl.slot_rd = div_done;
				slot_ra         = i_q[AW-1:0];
			end
			S_U_EMIT: begin
				slot_ra = i_q[AW-1:0];
				if (out_free) begin
					tbl_ctl.slot_we = 1'b1;
					slot_wa         = j_q;
					slot_wd         = slot_qa;
					tbl_ctl.clear   = last_el;
				end
			end
			default: begin
			end
		endcase
	end

	prru_tables #(
		.DEPTH (MAX_LAYERS),
		.AW    (AW)
	) u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.slot_ra (slot_ra),
		.slot_rb (slot_rb),
		.slot_wa (slot_wa),
		.slot_wd (slot_wd),
		.loc_ra  (loc_ra),
		.loc_wa  (loc_wa),
		.loc_wd  (loc_wd),
		.slot_qa (slot_qa),
		.slot_qb (slot_qb),
		.loc_q   (loc_q)
	);

	prru_divider #(
		.DW (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (idx_q),
		.divisor  (n_q - i_q),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	// Sequencer, rank state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= CNT_W'(N_RST);
			pos_q       <= '0;
			acc_q       <= '0;
			fac_q       <= RW'(1);
			err_q       <= 1'b0;
			e_q         <= '0;
			bad_q       <= 1'b0;
			s_q         <= '0;
			v_q         <= '0;
			prod_q      <= '0;
			idx_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_rank_q  <= '0;
			out_elem_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			div_start_q <= div_kick;
			// Load a new result, or drop the held one once it is taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						n_q   <= CNT_W'(clamp_v);
						pos_q <= '0;
						acc_q <= '0;
						fac_q <= RW'(1);
						err_q <= 1'b0;
					end else if (in_ch.valid) begin
						if (in_ch.action) begin
							pos_q       <= '0;
							acc_q       <= '0;
							fac_q       <= RW'(1);
							err_q       <= 1'b0;
							idx_q       <= in_ch.unrank_index;
							i_q         <= '0;
							state_q     <= S_U_DIV;
						end else begin
							e_q     <= in_ch.element_in;
							state_q <= S_R_READ;
						end
					end
				end
				S_R_READ: begin
					state_q <= S_R_CHECK;
				end
				S_R_CHECK: begin
					bad_q   <= bad;
					if (bad)
						err_q <= 1'b1;
					s_q     <= loc_q;
					v_q     <= slot_qa;
					prod_q  <= prod_full[RW-1:0];
					state_q <= S_R_ACC;
				end
				S_R_ACC: begin
					acc_q   <= acc_q + prod_q;
					prod_q  <= prod_full[RW-1:0];
					state_q <= S_R_FAC;
				end
				S_R_FAC: begin
					fac_q <= prod_q;
					pos_q <= pos_q + CNT_W'(1);
					if (pos_q + CNT_W'(1) == n_q)
						state_q <= S_R_EMIT;
					else
						state_q <= S_IDLE;
				end
				S_R_EMIT: begin
					if (out_free) begin
						out_kind_q  <= 1'b0;
						out_rank_q  <= err_q ? '0 : acc_q;
						out_elem_q  <= '0;
						out_last_q  <= 1'b1;
						out_err_q   <= err_q;
						pos_q       <= '0;
						acc_q       <= '0;
						fac_q       <= RW'(1);
						err_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_U_DIV: begin
					if (div_done) begin
						idx_q   <= div_quot;
						j_q     <= j_w;
						state_q <= S_U_EMIT;
					end
				end
				S_U_EMIT: begin
					if (out_free) begin
						out_kind_q  <= 1'b1;
						out_rank_q  <= '0;
						out_elem_q  <= EW'(slot_qb);
						out_last_q  <= last_el;
						out_err_q   <= 1'b0;
						if (last_el) begin
							state_q <= S_IDLE;
						end else begin
							i_q         <= i_q + CNT_W'(1);
							state_q     <= S_U_DIV;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE) && !cfg_we;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = out_kind_q;
	assign out_ch.rank_value  = out_rank_q;
	assign out_ch.element_out = out_elem_q;
	assign out_ch.last        = out_last_q;
	assign out_ch.error       = out_err_q;

	// Position stays below the layer count except while a rank result waits
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_R_EMIT) |-> (pos_q < n_q))
		else $error("rank position reached the layer count");

	// Divider results only arrive while unranking waits on them
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_U_DIV))
		else $error("divider finished outside an unrank step");

	// A rank result is always last, and an errored one carries zero
	a_rank_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.result_kind) |->
			(out_ch.last && (!out_ch.error || (out_ch.rank_value == '0))))
		else $error("malformed rank result");

endmodule

`default_nettype wire
